@@ src/lsfb_pkg.sv @@
// Package for the LED strip frame byte generator.
// Holds sizes, opcode and register codes, the controller state type and the
// controller-to-datapath command struct. No dependencies.
package lsfb_pkg;

  localparam int BUFFER_BYTES   = 128;
  localparam int PREAMBLE_BYTES = 4;
  localparam int MAX_PIXELS     = 32;

  localparam int ADDR_W    = $clog2(BUFFER_BYTES);
  localparam int POS_W     = $clog2(PREAMBLE_BYTES + MAX_PIXELS * 4);
  localparam int PIXCNT_W  = 6;
  localparam int OFFSET_W  = 7;
  localparam int INDEX_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0]  VALUE_LIMIT = 8'd120;
  localparam logic [15:0] REGION_RECIP = 16'd48771;
  localparam logic [7:0]  REGION_SPAN = 8'd43;
  localparam logic [7:0]  LED_HEADER = 8'hff;
  localparam logic [7:0]  PREAMBLE_BYTE = 8'h00;

  typedef enum logic {
    OP_TX    = 1'b0,
    OP_WRITE = 1'b1
  } lsfb_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_MODE   = 3'd0,
    CFG_HUE           = 3'd1,
    CFG_SATURATION    = 3'd2,
    CFG_BRIGHTNESS    = 3'd3,
    CFG_PIXEL_COUNT   = 3'd4,
    CFG_BUFFER_OFFSET = 3'd5
  } lsfb_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REGION,
    ST_FRAC,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } lsfb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic buf_write;
    logic region_en;
    logic frac_en;
    logic mul1_en;
    logic mul2_en;
    logic load_out;
  } lsfb_ctl_t;

endpackage

@@ src/lsfb_if.sv @@
// Valid/ready channel interfaces for the LED strip frame byte generator.
// Depends on lsfb_pkg for field widths.
interface lsfb_item_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [lsfb_pkg::INDEX_W-1:0]   buffer_index;
  logic [7:0]                     buffer_data;

  modport source (output valid, opcode, buffer_index, buffer_data, input ready);
  modport sink (input valid, opcode, buffer_index, buffer_data, output ready);
endinterface

interface lsfb_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        last_of_frame;
  logic [15:0] frames_done;

  modport source (output valid, tx_byte, last_of_frame, frames_done, input ready);
  modport sink (input valid, tx_byte, last_of_frame, frames_done, output ready);
endinterface

@@ src/led_strip_frame_byte_generator_core.sv @@
// LED strip frame byte generator. Each transmit item yields one byte of an
// addressable LED strip frame (four zero bytes, then four bytes per pixel:
// 0xff, blue, green, red in global mode, else bytes from the pixel buffer),
// with the last byte of each frame marked and the frame count reported. A
// write item stores one pixel buffer byte, yields nothing and is taken in
// the idle state. A transmit item runs the four-step HSV-to-RGB sequence
// (one multiply rank per step) and then the output load before its byte
// appears on the frame channel; the next item is accepted in the cycle after
// the load, while the byte still waits in the output register. The load step
// holds for as long as the previous byte is still unclaimed. Buffer entries
// must be written before a frame reads them. Depends on lsfb_pkg, lsfb_if,
// lsfb_ctrl and lsfb_datapath.
module led_strip_frame_byte_generator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lsfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsfb_pkg::CFG_DATA_W-1:0] cfg_data,
  lsfb_item_if.sink                       item,
  lsfb_frame_if.source                    frame
);
  import lsfb_pkg::*;

  lsfb_ctl_t ctl;

  lsfb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_opcode (item.opcode),
    .item_ready  (item.ready),
    .out_ready   (frame.ready),
    .out_valid   (frame.valid),
    .ctl         (ctl)
  );

  lsfb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ctl           (ctl),
    .item_index    (item.buffer_index),
    .item_data     (item.buffer_data),
    .tx_byte       (frame.tx_byte),
    .last_of_frame (frame.last_of_frame),
    .frames_done   (frame.frames_done)
  );

endmodule

@@ src/lsfb_ctrl.sv @@
// Controller for the LED strip frame byte generator: sequences the color
// computation and the output register load. Depends on lsfb_pkg.
module lsfb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_opcode,
  output logic               item_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output lsfb_pkg::lsfb_ctl_t ctl
);
  import lsfb_pkg::*;

  lsfb_state_t state, state_next;
  logic        out_valid_next;
  logic        slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    item_ready     = 1'b0;
    ctl            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_opcode == OP_WRITE) begin
            ctl.buf_write = 1'b1;
          end else begin
            state_next = ST_REGION;
          end
        end
      end
      ST_REGION: begin
        ctl.region_en = 1'b1;
        state_next    = ST_FRAC;
      end
      ST_FRAC: begin
        ctl.frac_en = 1'b1;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        ctl.mul1_en = 1'b1;
        state_next  = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.mul2_en = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        // Wait here while the previous byte is still unclaimed.
        if (slot_free) begin
          ctl.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_tx_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_opcode == OP_TX) |=> state == ST_REGION)
    else $error("transmit item did not start the color sequence");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("loaded byte not presented");

  a_mul2_then_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL2 |=> state == ST_LOAD)
    else $error("sequence skipped the load step");

endmodule

@@ src/lsfb_datapath.sv @@
// Datapath for the LED strip frame byte generator: configuration registers,
// pixel buffer, HSV-to-RGB stages, frame position and output register.
// Depends on lsfb_pkg.
module lsfb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lsfb_pkg::lsfb_ctl_t           ctl,
  input  logic [lsfb_pkg::INDEX_W-1:0]  item_index,
  input  logic [7:0]                    item_data,
  output logic [7:0]                    tx_byte,
  output logic                          last_of_frame,
  output logic [15:0]                   frames_done
);
  import lsfb_pkg::*;

  // Configuration registers.
  logic                global_mode;
  logic [7:0]          hue;
  logic [7:0]          saturation;
  logic [7:0]          brightness;
  logic [PIXCNT_W-1:0] pixel_count;
  logic [OFFSET_W-1:0] buffer_offset;
  logic [PIXCNT_W-1:0] pixcnt_clamped;

  // Frame state.
  logic [POS_W-1:0] byte_pos;
  logic [15:0]      frame_counter;

  // Pixel buffer.
  logic [7:0] pbuf [BUFFER_BYTES];
  logic [7:0] rdata;

  // Color pipeline registers.
  logic [2:0] region;
  logic [7:0] frac;
  logic [7:0] p_val, sf, sg, q_val, t_val;

  logic [7:0]  vclamp;
  logic [23:0] region_prod;
  logic [7:0]  frac_diff;
  logic [10:0] frac_prod;
  logic [15:0] p_prod, sf_prod, sg_prod, q_prod, t_prod;

  logic [POS_W-1:0] rel;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   frame_len;
  logic             is_last;
  logic [7:0]       red, green, blue;
  logic [7:0]       byte_sel;

  always_comb begin
    pixcnt_clamped = cfg_data[PIXCNT_W-1:0];
    if (pixcnt_clamped == '0) begin
      pixcnt_clamped = PIXCNT_W'(1);
    end else if (pixcnt_clamped > PIXCNT_W'(MAX_PIXELS)) begin
      pixcnt_clamped = PIXCNT_W'(MAX_PIXELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_mode   <= 1'b1;
      hue           <= '0;
      saturation    <= '0;
      brightness    <= '0;
      pixel_count   <= PIXCNT_W'(1);
      buffer_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLOBAL_MODE:   global_mode   <= cfg_data[0];
        CFG_HUE:           hue           <= cfg_data[7:0];
        CFG_SATURATION:    saturation    <= cfg_data[7:0];
        CFG_BRIGHTNESS:    brightness    <= cfg_data[7:0];
        CFG_PIXEL_COUNT:   pixel_count   <= pixcnt_clamped;
        CFG_BUFFER_OFFSET: buffer_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer byte address: offset from the first pixel byte, wrapping at the
  // buffer size.
  assign rel     = byte_pos - POS_W'(PREAMBLE_BYTES);
  assign rd_addr = ADDR_W'(rel) + ADDR_W'(buffer_offset);

  always_ff @(posedge clk) begin
    if (ctl.buf_write) begin
      pbuf[item_index[ADDR_W-1:0]] <= item_data;
    end
    if (ctl.mul1_en) begin
      rdata <= pbuf[rd_addr];
    end
  end

  assign vclamp      = (brightness > VALUE_LIMIT) ? VALUE_LIMIT : brightness;
  assign region_prod = {16'd0, hue} * {8'd0, REGION_RECIP};
  assign frac_diff   = hue - 8'({5'd0, region} * REGION_SPAN);
  assign frac_prod   = {3'd0, frac_diff} * 11'd6;
  assign p_prod      = {8'd0, vclamp} * {8'd0, ~saturation};
  assign sf_prod     = {8'd0, saturation} * {8'd0, frac};
  assign sg_prod     = {8'd0, saturation} * {8'd0, ~frac};
  assign q_prod      = {8'd0, vclamp} * {8'd0, ~sf};
  assign t_prod      = {8'd0, vclamp} * {8'd0, ~sg};

  always_ff @(posedge clk) begin
    if (ctl.region_en) begin
      region <= region_prod[23:21];
    end
    if (ctl.frac_en) begin
      frac <= frac_prod[7:0];
    end
    if (ctl.mul1_en) begin
      p_val <= p_prod[15:8];
      sf    <= sf_prod[15:8];
      sg    <= sg_prod[15:8];
    end
    if (ctl.mul2_en) begin
      q_val <= q_prod[15:8];
      t_val <= t_prod[15:8];
    end
  end

  always_comb begin
    if (saturation == 8'd0) begin
      red   = vclamp;
      green = vclamp;
      blue  = vclamp;
    end else begin
      case (region)
        3'd0: begin red = vclamp; green = t_val;  blue = p_val;  end
        3'd1: begin red = q_val;  green = vclamp; blue = p_val;  end
        3'd2: begin red = p_val;  green = vclamp; blue = t_val;  end
        3'd3: begin red = p_val;  green = q_val;  blue = vclamp; end
        3'd4: begin red = t_val;  green = p_val;  blue = vclamp; end
        default: begin red = vclamp; green = p_val; blue = q_val; end
      endcase
    end
  end

  always_comb begin
    if (byte_pos < POS_W'(PREAMBLE_BYTES)) begin
      byte_sel = PREAMBLE_BYTE;
    end else if (global_mode) begin
      case (rel[1:0])
        2'd0:    byte_sel = LED_HEADER;
        2'd1:    byte_sel = blue;
        2'd2:    byte_sel = green;
        default: byte_sel = red;
      endcase
    end else begin
      byte_sel = rdata;
    end
  end

  assign frame_len = (POS_W+1)'(PREAMBLE_BYTES) + {1'b0, POS_W'({pixel_count, 2'b00})};
  assign pos_inc   = {1'b0, byte_pos} + (POS_W+1)'(1);
  assign is_last   = pos_inc >= frame_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      frame_counter <= '0;
    end else if (ctl.load_out) begin
      if (is_last) begin
        byte_pos      <= '0;
        frame_counter <= frame_counter + 16'd1;
      end else begin
        byte_pos <= pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      tx_byte       <= byte_sel;
      last_of_frame <= is_last;
      frames_done   <= is_last ? frame_counter + 16'd1 : frame_counter;
    end
  end

endmodule
